@@ hw/rtl/pidfd_pkg.sv @@
package pidfd_pkg;

    localparam int DATA_WIDTH      = 32;
    localparam int FRAC_BITS       = 16;
    localparam int STEP_FRAC       = 16;
    localparam int STEP_WIDTH      = 16;
    localparam int ALPHA_WIDTH     = 17;
    localparam int LIMIT_WIDTH     = 31;
    localparam int CFG_INDEX_WIDTH = 3;
    localparam int MUL_WIDTH       = DATA_WIDTH + 1;
    localparam int PROD_WIDTH      = 2 * MUL_WIDTH;
    localparam int DIV_WIDTH       = DATA_WIDTH + STEP_FRAC;
    localparam int CNT_WIDTH       = $clog2(DIV_WIDTH);
    localparam int WIDE_WIDTH      = DATA_WIDTH + 2;

    localparam logic [ALPHA_WIDTH-1:0] ALPHA_ONE = ALPHA_WIDTH'(1 << STEP_FRAC);

    localparam logic signed [DATA_WIDTH-1:0] VMAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam logic signed [DATA_WIDTH-1:0] VMIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};
    localparam logic signed [WIDE_WIDTH-1:0] WMAX = {3'b000, {(DATA_WIDTH-1){1'b1}}};
    localparam logic signed [WIDE_WIDTH-1:0] WMIN = {3'b111, {(DATA_WIDTH-1){1'b0}}};

    localparam logic [1:0] OP_STEP  = 2'd0;
    localparam logic [1:0] OP_CLEAR = 2'd1;
    localparam logic [1:0] OP_LOAD  = 2'd2;
    localparam logic [1:0] OP_SPARE = 2'd3;

    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_GAIN_P = 3'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_GAIN_I = 3'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_GAIN_D = 3'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_LIMIT  = 3'd3;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_ALPHA  = 3'd4;

    typedef struct packed {
        logic [1:0]                   opcode;
        logic signed [DATA_WIDTH-1:0] error_value;
        logic [STEP_WIDTH-1:0]        dt_value;
        logic signed [DATA_WIDTH-1:0] load_value;
    } t_in_item;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] drive;
        logic signed [DATA_WIDTH-1:0] integrator_now;
    } t_out_item;

    typedef enum logic [3:0] {
        S_IDLE, S_MUL_P, S_SH_P, S_MUL_I1, S_SH_I1, S_MUL_I2, S_SH_I2,
        S_DIV_INIT, S_DIV, S_DIV_END, S_MUL_F, S_SH_F, S_MUL_D, S_SH_D, S_FINISH
    } t_state;

    typedef enum logic [3:0] {
        CMD_NONE, CMD_LOAD, CMD_MUL_P, CMD_SH_P, CMD_MUL_I1, CMD_SH_I1, CMD_MUL_I2,
        CMD_SH_I2, CMD_DIV_INIT, CMD_DIV_STEP, CMD_DIV_END, CMD_MUL_F, CMD_SH_F,
        CMD_MUL_D, CMD_SH_D, CMD_FINISH
    } t_cmd;

    typedef struct packed {
        logic is_step;
        logic do_i;
        logic do_d;
        logic slope_valid;
        logic div_last;
    } t_status;

    function automatic logic signed [DATA_WIDTH-1:0] mul_sat(
        input logic [PROD_WIDTH-1:0] prod, input logic neg, input logic step);
        logic [PROD_WIDTH-1:0] rl;
        rl = step ? (prod >> STEP_FRAC) : (prod >> FRAC_BITS);
        if (rl > PROD_WIDTH'(VMAX)) begin
            return neg ? VMIN : VMAX;
        end
        return neg ? -$signed(rl[DATA_WIDTH-1:0]) : $signed(rl[DATA_WIDTH-1:0]);
    endfunction

    function automatic logic signed [DATA_WIDTH-1:0] sat_wide(
        input logic signed [WIDE_WIDTH-1:0] v);
        if (v > WMAX) begin
            return VMAX;
        end
        if (v < WMIN) begin
            return VMIN;
        end
        return v[DATA_WIDTH-1:0];
    endfunction

endpackage

@@ hw/rtl/pidfd_ctrl.sv @@
module pidfd_ctrl
    import pidfd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_stall,
    output logic    o_out_valid,
    input  logic    i_out_stall,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:     if (i_in_valid) n_state = S_MUL_P;
            S_MUL_P:    n_state = S_SH_P;
            S_SH_P: begin
                if (!i_status.is_step) n_state = S_FINISH;
                else if (i_status.do_i) n_state = S_MUL_I1;
                else if (i_status.do_d) n_state = S_DIV_INIT;
                else n_state = S_FINISH;
            end
            S_MUL_I1:   n_state = S_SH_I1;
            S_SH_I1:    n_state = S_MUL_I2;
            S_MUL_I2:   n_state = S_SH_I2;
            S_SH_I2:    n_state = i_status.do_d ? S_DIV_INIT : S_FINISH;
            S_DIV_INIT: n_state = i_status.slope_valid ? S_DIV : S_MUL_F;
            S_DIV:      if (i_status.div_last) n_state = S_DIV_END;
            S_DIV_END:  n_state = S_MUL_F;
            S_MUL_F:    n_state = S_SH_F;
            S_SH_F:     n_state = S_MUL_D;
            S_MUL_D:    n_state = S_SH_D;
            S_SH_D:     n_state = S_FINISH;
            S_FINISH:   if (out_free) n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = CMD_NONE;
        unique case (r_state)
            S_IDLE:     o_cmd = i_in_valid ? CMD_LOAD : CMD_NONE;
            S_MUL_P:    o_cmd = CMD_MUL_P;
            S_SH_P:     o_cmd = CMD_SH_P;
            S_MUL_I1:   o_cmd = CMD_MUL_I1;
            S_SH_I1:    o_cmd = CMD_SH_I1;
            S_MUL_I2:   o_cmd = CMD_MUL_I2;
            S_SH_I2:    o_cmd = CMD_SH_I2;
            S_DIV_INIT: o_cmd = CMD_DIV_INIT;
            S_DIV:      o_cmd = CMD_DIV_STEP;
            S_DIV_END:  o_cmd = CMD_DIV_END;
            S_MUL_F:    o_cmd = CMD_MUL_F;
            S_SH_F:     o_cmd = CMD_SH_F;
            S_MUL_D:    o_cmd = CMD_MUL_D;
            S_SH_D:     o_cmd = CMD_SH_D;
            S_FINISH:   o_cmd = out_free ? CMD_FINISH : CMD_NONE;
            default:    o_cmd = CMD_NONE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        priority if (r_state == S_FINISH && out_free) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

@@ hw/rtl/pidfd_datapath.sv @@
module pidfd_datapath
    import pidfd_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_write,
    input  logic [CFG_INDEX_WIDTH-1:0] i_cfg_index,
    input  logic [DATA_WIDTH-1:0]      i_cfg_data,
    input  t_in_item                   i_in_data,
    input  t_cmd                       i_cmd,
    output t_status                    o_status,
    output t_out_item                  o_out_data
);

    logic signed [DATA_WIDTH-1:0] r_gain_p, r_gain_i, r_gain_d;
    logic [LIMIT_WIDTH-1:0]       r_limit;
    logic [ALPHA_WIDTH-1:0]       r_alpha;

    logic [1:0]                   r_op;
    logic signed [DATA_WIDTH-1:0] r_err;
    logic [STEP_WIDTH-1:0]        r_dt;

    logic signed [DATA_WIDTH-1:0] r_isum, r_prev, r_filt;
    logic                         r_slope_valid;

    logic signed [DATA_WIDTH-1:0] r_p, r_i, r_d, r_t, r_slope;
    logic [PROD_WIDTH-1:0]        r_prod;
    logic                         r_neg, r_step_sh, r_dneg;
    logic [DIV_WIDTH-1:0]         r_dq;
    logic [STEP_WIDTH-1:0]        r_rem;
    logic [CNT_WIDTH-1:0]         r_cnt;
    t_out_item                    r_out;

    logic signed [MUL_WIDTH-1:0]  mul_a, mul_b;
    logic [MUL_WIDTH-1:0]         mag_a, mag_b;
    logic [ALPHA_WIDTH-1:0]       alpha_eff;
    logic signed [DATA_WIDTH-1:0] sh_res, sum_i, lim, clamp_i, sum_f;
    logic signed [MUL_WIDTH-1:0]  diff;
    logic [MUL_WIDTH-1:0]         diff_mag;
    logic [STEP_WIDTH:0]          rem_sh;
    logic                         ge;

    assign alpha_eff = (r_alpha > ALPHA_ONE) ? ALPHA_ONE : r_alpha;

    // operand select for the shared multiplier
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (i_cmd)
            CMD_MUL_P: begin
                mul_a = MUL_WIDTH'(r_err);
                mul_b = MUL_WIDTH'(r_gain_p);
            end
            CMD_MUL_I1: begin
                mul_a = MUL_WIDTH'(r_err);
                mul_b = MUL_WIDTH'(r_gain_i);
            end
            CMD_MUL_I2: begin
                mul_a = MUL_WIDTH'(r_t);
                mul_b = $signed(MUL_WIDTH'(r_dt));
            end
            CMD_MUL_F: begin
                mul_a = $signed(MUL_WIDTH'(alpha_eff));
                mul_b = MUL_WIDTH'(r_slope) - MUL_WIDTH'(r_filt);
            end
            CMD_MUL_D: begin
                mul_a = MUL_WIDTH'(r_gain_d);
                mul_b = MUL_WIDTH'(r_filt);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mag_a = mul_a[MUL_WIDTH-1] ? MUL_WIDTH'(-mul_a) : MUL_WIDTH'(mul_a);
    assign mag_b = mul_b[MUL_WIDTH-1] ? MUL_WIDTH'(-mul_b) : MUL_WIDTH'(mul_b);

    assign sh_res = mul_sat(r_prod, r_neg, r_step_sh);
    assign sum_i  = sat_wide(WIDE_WIDTH'(r_isum) + WIDE_WIDTH'(sh_res));
    assign lim    = $signed(DATA_WIDTH'(r_limit));
    always_comb begin
        priority if (sum_i < -lim) begin
            clamp_i = -lim;
        end else if (sum_i > lim) begin
            clamp_i = lim;
        end else begin
            clamp_i = sum_i;
        end
    end
    assign sum_f = sat_wide(WIDE_WIDTH'(r_filt) + WIDE_WIDTH'(sh_res));

    assign diff     = MUL_WIDTH'(r_err) - MUL_WIDTH'(r_prev);
    assign diff_mag = diff[MUL_WIDTH-1] ? MUL_WIDTH'(-diff) : MUL_WIDTH'(diff);

    assign rem_sh = {r_rem, r_dq[DIV_WIDTH-1]};
    assign ge     = (rem_sh >= {1'b0, r_dt});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_p      <= '0;
            r_gain_i      <= '0;
            r_gain_d      <= '0;
            r_limit       <= '0;
            r_alpha       <= '0;
            r_isum        <= '0;
            r_prev        <= '0;
            r_filt        <= '0;
            r_slope_valid <= 1'b1;
            r_cnt         <= '0;
        end else begin
            if (i_cfg_write) begin
                unique case (i_cfg_index)
                    CFG_GAIN_P: r_gain_p <= $signed(i_cfg_data);
                    CFG_GAIN_I: r_gain_i <= $signed(i_cfg_data);
                    CFG_GAIN_D: r_gain_d <= $signed(i_cfg_data);
                    CFG_LIMIT:  r_limit  <= i_cfg_data[LIMIT_WIDTH-1:0];
                    CFG_ALPHA:  r_alpha  <= i_cfg_data[ALPHA_WIDTH-1:0];
                    default: ;
                endcase
            end
            unique case (i_cmd)
                CMD_LOAD: begin
                    if (i_in_data.opcode == OP_CLEAR) begin
                        r_isum        <= '0;
                        r_filt        <= '0;
                        r_slope_valid <= 1'b0;
                    end else if (i_in_data.opcode == OP_LOAD) begin
                        r_isum <= i_in_data.load_value;
                    end
                end
                CMD_SH_I2: r_isum <= clamp_i;
                CMD_DIV_INIT: begin
                    r_cnt <= '0;
                    if (!r_slope_valid) begin
                        r_filt        <= '0;
                        r_slope_valid <= 1'b1;
                    end
                end
                CMD_DIV_STEP: r_cnt <= r_cnt + 1'b1;
                CMD_SH_F: begin
                    r_filt <= sum_f;
                    r_prev <= r_err;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (i_cmd)
            CMD_LOAD: begin
                r_op  <= i_in_data.opcode;
                r_err <= i_in_data.error_value;
                r_dt  <= i_in_data.dt_value;
                r_p   <= '0;
                r_i   <= '0;
                r_d   <= '0;
            end
            CMD_MUL_P, CMD_MUL_I1, CMD_MUL_D: begin
                r_prod    <= PROD_WIDTH'(mag_a) * PROD_WIDTH'(mag_b);
                r_neg     <= mul_a[MUL_WIDTH-1] ^ mul_b[MUL_WIDTH-1];
                r_step_sh <= 1'b0;
            end
            CMD_MUL_I2, CMD_MUL_F: begin
                r_prod    <= PROD_WIDTH'(mag_a) * PROD_WIDTH'(mag_b);
                r_neg     <= mul_a[MUL_WIDTH-1] ^ mul_b[MUL_WIDTH-1];
                r_step_sh <= 1'b1;
            end
            CMD_SH_P:  r_p <= (r_op == OP_STEP) ? sh_res : '0;
            CMD_SH_I1: r_t <= sh_res;
            CMD_SH_I2: r_i <= clamp_i;
            CMD_DIV_INIT: begin
                r_slope <= '0;
                r_dneg  <= diff[MUL_WIDTH-1];
                r_dq    <= {diff_mag[DATA_WIDTH-1:0], {STEP_FRAC{1'b0}}};
                r_rem   <= '0;
            end
            CMD_DIV_STEP: begin
                r_rem <= ge ? STEP_WIDTH'(rem_sh - {1'b0, r_dt}) : rem_sh[STEP_WIDTH-1:0];
                r_dq  <= {r_dq[DIV_WIDTH-2:0], ge};
            end
            CMD_DIV_END: begin
                if (r_dq > DIV_WIDTH'(VMAX)) begin
                    r_slope <= r_dneg ? VMIN : VMAX;
                end else begin
                    r_slope <= r_dneg ? -$signed(r_dq[DATA_WIDTH-1:0])
                                      : $signed(r_dq[DATA_WIDTH-1:0]);
                end
            end
            CMD_SH_D: r_d <= sh_res;
            CMD_FINISH: begin
                r_out.drive <= sat_wide(WIDE_WIDTH'(r_p) + WIDE_WIDTH'(r_i) + WIDE_WIDTH'(r_d));
                r_out.integrator_now <= r_isum;
            end
            default: ;
        endcase
    end

    assign o_status.is_step     = (r_op == OP_STEP);
    assign o_status.do_i        = (r_gain_i != '0) && (r_dt != '0);
    assign o_status.do_d        = (r_gain_d != '0) && (r_dt != '0);
    assign o_status.slope_valid = r_slope_valid;
    assign o_status.div_last    = (r_cnt == CNT_WIDTH'(DIV_WIDTH - 1));
    assign o_out_data           = r_out;

endmodule

@@ hw/rtl/pid_controller_filtered_derivative_unit.sv @@
// clear, load and unused opcodes take the short path: proportional multiply, shift, finish;
// a full step adds the shared multiplier passes and the 48-step bit-serial slope divide;
// shorter when I or D is skipped
// one item at a time: the input stalls until the result is registered, the next item can be
// taken in the cycle after that, and finishing waits while the output is stalled
// reset: synchronous active low; clears config registers, integrator, previous error and filter, slope marked valid
module pid_controller_filtered_derivative_unit
    import pidfd_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  t_in_item                   i_in_data,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output t_out_item                  o_out_data,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [CFG_INDEX_WIDTH-1:0] i_cfg_index,
    input  logic [DATA_WIDTH-1:0]      i_cfg_data
);

    t_cmd    cmd;
    t_status status;

    assign o_cfg_ready = 1'b1;

    pidfd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    pidfd_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_write (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_out_data  (o_out_data)
    );

endmodule

@@ sim/tb_pid_controller_filtered_derivative_unit.sv @@
`timescale 1ns / 100ps

module tb_pid_controller_filtered_derivative_unit;
    import pidfd_pkg::*;

    localparam longint LMAX = 64'sd2147483647;
    localparam longint LMIN = -64'sd2147483648;

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       in_valid;
    logic                       o_in_stall;
    t_in_item                   in_data;
    logic                       o_out_valid;
    logic                       out_stall;
    t_out_item                  o_out_data;
    logic                       cfg_valid;
    logic                       o_cfg_ready;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index;
    logic [DATA_WIDTH-1:0]      cfg_data;

    pid_controller_filtered_derivative_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    // controller model state and registers
    longint    kp, ki, kd, ilimit, alpha;
    longint    integ, prev_err, filt;
    bit        slope_ok;

    t_in_item  item_q[$];
    t_out_item drive_q[$];
    int        sender_idle, recv_idle;
    logic      in_taken;
    int        mismatches, items_sent, results_seen, cfg_writes;

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    function automatic longint sat(longint v);
        if (v > LMAX) begin
            return LMAX;
        end
        if (v < LMIN) begin
            return LMIN;
        end
        return v;
    endfunction

    function automatic longint mul_trunc(longint a, longint b, int sh);
        logic [127:0] ua, ub, pr;
        logic         neg;
        neg = (a < 0) != (b < 0);
        ua = a < 0 ? 128'(-a) : 128'(a);
        ub = b < 0 ? 128'(-b) : 128'(b);
        pr = (ua * ub) >> sh;
        if (pr > 128'(LMAX)) begin
            return neg ? LMIN : LMAX;
        end
        return neg ? -longint'(pr[63:0]) : longint'(pr[63:0]);
    endfunction

    function automatic longint slope_div(longint diff, longint dt);
        longint u, q, r, res;
        u = diff < 0 ? -diff : diff;
        q = u / dt;
        r = u % dt;
        if (q > (LMAX >>> STEP_FRAC)) begin
            return diff < 0 ? LMIN : LMAX;
        end
        res = (q <<< STEP_FRAC) + ((r <<< STEP_FRAC) / dt);
        if (res > LMAX) begin
            res = LMAX;
        end
        return diff < 0 ? -res : res;
    endfunction

    function automatic t_out_item predict_control(t_in_item it);
        t_out_item o;
        longint    err, dt, p, t, s, sl, a, drv;
        err = longint'(it.error_value);
        dt  = longint'(it.dt_value);
        drv = 0;
        if (it.opcode == OP_STEP) begin
            p = mul_trunc(err, kp, FRAC_BITS);
            t = 0;
            sl = 0;
            if (ki != 0 && dt != 0) begin
                s = sat(integ + mul_trunc(mul_trunc(err, ki, FRAC_BITS), dt, STEP_FRAC));
                if (s < -ilimit) begin
                    s = -ilimit;
                end else if (s > ilimit) begin
                    s = ilimit;
                end
                integ = s;
                t = s;
            end
            if (kd != 0 && dt != 0) begin
                a = alpha > 65536 ? 65536 : alpha;
                if (!slope_ok) begin
                    s = 0;
                    filt = 0;
                    slope_ok = 1'b1;
                end else begin
                    s = slope_div(err - prev_err, dt);
                end
                s = sat(filt + mul_trunc(a, s - filt, STEP_FRAC));
                prev_err = err;
                filt = s;
                sl = mul_trunc(kd, s, FRAC_BITS);
            end
            drv = sat(p + t + sl);
        end else if (it.opcode == OP_CLEAR) begin
            integ = 0;
            filt = 0;
            slope_ok = 1'b0;
        end else if (it.opcode == OP_LOAD) begin
            integ = longint'(it.load_value);
        end
        o.drive = drv[31:0];
        o.integrator_now = integ[31:0];
        return o;
    endfunction

    // driver
    always @(negedge i_clk) begin
        out_stall <= ($urandom_range(99) < recv_idle);
        if (!in_valid || in_taken) begin
            if (item_q.size() > 0 && $urandom_range(99) >= sender_idle) begin
                in_data <= item_q[0];
                in_valid <= 1'b1;
                drive_q.push_back(predict_control(item_q.pop_front()));
                items_sent++;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        in_taken <= in_valid && !o_in_stall;
        if (i_rst_n && o_out_valid && !out_stall) begin
            results_seen++;
            if (drive_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected result drive=%0d integ=%0d",
                             o_out_data.drive, o_out_data.integrator_now);
                end
            end else begin
                if (o_out_data !== drive_q[0]) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch: drive exp %0d got %0d, integ exp %0d got %0d",
                                 drive_q[0].drive, o_out_data.drive,
                                 drive_q[0].integrator_now, o_out_data.integrator_now);
                    end
                end
                void'(drive_q.pop_front());
            end
        end
    end

    task automatic write_reg(logic [CFG_INDEX_WIDTH-1:0] idx, logic [31:0] val);
        @(negedge i_clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        cfg_valid = 1'b0;
        cfg_writes++;
        case (idx)
            CFG_GAIN_P: kp = longint'($signed(val));
            CFG_GAIN_I: ki = longint'($signed(val));
            CFG_GAIN_D: kd = longint'($signed(val));
            CFG_LIMIT:  ilimit = longint'({1'b0, val[30:0]});
            CFG_ALPHA:  alpha = longint'(val[16:0]);
            default: ;
        endcase
    endtask

    task automatic write_all(logic [31:0] gp, logic [31:0] gi, logic [31:0] gd,
                             logic [31:0] lim, logic [31:0] al);
        write_reg(CFG_GAIN_P, gp);
        write_reg(CFG_GAIN_I, gi);
        write_reg(CFG_GAIN_D, gd);
        write_reg(CFG_LIMIT, lim);
        write_reg(CFG_ALPHA, al);
    endtask

    function automatic logic [31:0] rand_value();
        logic [31:0] v;
        if ($urandom_range(3) == 0) begin
            return $urandom;
        end
        v = $urandom_range(0, 32'h40000);
        return $urandom_range(1) ? -v : v;
    endfunction

    function automatic t_in_item rand_item();
        t_in_item it;
        int       k;
        k = $urandom_range(99);
        it.opcode = k < 70 ? OP_STEP : k < 80 ? OP_CLEAR : k < 90 ? OP_LOAD : OP_SPARE;
        it.error_value = rand_value();
        k = $urandom_range(9);
        it.dt_value = k == 0 ? 16'd0 : k == 1 ? 16'hFFFF : k == 2 ? 16'd1
                    : 16'($urandom);
        it.load_value = rand_value();
        return it;
    endfunction

    task automatic add_item(logic [1:0] op, logic [31:0] e, logic [15:0] dt,
                            logic [31:0] ld);
        t_in_item it;
        it.opcode = op;
        it.error_value = e;
        it.dt_value = dt;
        it.load_value = ld;
        item_q.push_back(it);
    endtask

    task automatic wait_idle();
        while (item_q.size() > 0 || in_valid || drive_q.size() > 0) begin
            @(posedge i_clk);
        end
        repeat (70) @(posedge i_clk);
    endtask

    initial begin
        i_rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        in_taken = 1'b0;
        out_stall = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        sender_idle = 25;
        recv_idle = 87;
        kp = 0; ki = 0; kd = 0; ilimit = 0; alpha = 0;
        integ = 0; prev_err = 0; filt = 0; slope_ok = 1'b1;
        mismatches = 0; items_sent = 0; results_seen = 0; cfg_writes = 0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        for (int ph = 0; ph < 6; ph++) begin
            sender_idle = ph < 2 ? 25 : ph < 4 ? 87 : 0;
            recv_idle   = ph < 2 ? 87 : ph < 4 ? 25 : 0;
            if (ph > 0) begin
                wait_idle();
            end
            case (ph)
                0: write_all(32'h10000, 32'h8000, 32'h4000, 32'h640000, 32'h8000);
                1: write_all(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF,
                             32'hFFFFFFFF, 32'h1FFFF);
                2: write_all(32'h80000000, 32'h0, 32'h0, 32'h0, 32'h0);
                default: write_all(rand_value(), rand_value(), rand_value(),
                                   $urandom_range(0, 3) == 0 ? $urandom
                                                             : $urandom_range(0, 32'h200000),
                                   $urandom_range(0, 3) == 0 ? 32'h10000
                                                             : $urandom_range(0, 32'h1FFFF));
            endcase
            if (ph == 0) begin
                add_item(OP_STEP, 32'h0, 16'h0, 32'h0);
                add_item(OP_STEP, 32'h7FFFFFFF, 16'hFFFF, 32'hFFFFFFFF);
                add_item(OP_STEP, 32'h80000000, 16'h1, 32'h0);
                add_item(OP_STEP, 32'h10000, 16'h1, 32'h0);
                add_item(OP_CLEAR, 32'h7FFFFFFF, 16'h100, 32'h7FFFFFFF);
                add_item(OP_STEP, 32'h20000, 16'h0, 32'h0);
                add_item(OP_STEP, 32'h20000, 16'h1000, 32'h0);
                add_item(OP_STEP, 32'h30000, 16'h1000, 32'h0);
                add_item(OP_LOAD, 32'h0, 16'h0, 32'h7FFFFFFF);
                add_item(OP_STEP, 32'h7FFFFFFF, 16'hFFFF, 32'h0);
                add_item(OP_LOAD, 32'h0, 16'h0, 32'h80000000);
                add_item(OP_STEP, 32'h80000000, 16'hFFFF, 32'h0);
                add_item(OP_SPARE, 32'hFFFFFFFF, 16'hFFFF, 32'hFFFFFFFF);
                add_item(OP_STEP, 32'hFFFF0000, 16'h8000, 32'h0);
                add_item(OP_CLEAR, 32'h0, 16'h0, 32'h0);
                add_item(OP_STEP, 32'h50000, 16'h400, 32'h0);
                add_item(OP_STEP, 32'h80000000, 16'h1, 32'h0);
                add_item(OP_STEP, 32'h7FFFFFFF, 16'h1, 32'h0);
            end
            for (int n = 0; n < 134; n++) begin
                item_q.push_back(rand_item());
            end
        end
        wait_idle();
        $display("run covered %0d items, %0d results, %0d register writes, six settings",
                 items_sent, results_seen, cfg_writes);
        $display("%0d mismatches found", mismatches);
        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("timeout with %0d results outstanding", drive_q.size());
        $display("CHECK FAILED");
        $finish;
    end

endmodule

@@ files.f @@
hw/rtl/pidfd_pkg.sv
hw/rtl/pidfd_ctrl.sv
hw/rtl/pidfd_datapath.sv
hw/rtl/pid_controller_filtered_derivative_unit.sv
sim/tb_pid_controller_filtered_derivative_unit.sv
